// File: rtl/core/bba_pkg.sv
`default_nettype none
package bba_pkg;
  localparam int MAX_ORDER = 10;
  localparam int MARKS = (1 << (MAX_ORDER + 1)) - 1;
  localparam int AW = $clog2(MARKS);
  localparam int LW = 4;
  localparam int BW = 10;
  localparam int SW = 11;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_ZERO = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_MEM = 3'd3,
    ST_BAD_FREE = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SPLIT,
    S_FREE_RD, S_FREE_CHK, S_FREE_SET, S_DONE
  } state_t;

  typedef struct packed {
    logic op;
    logic [SW-1:0] size_blocks;
    logic [BW-1:0] block_index;
  } in_t;

  typedef struct packed {
    logic [BW-1:0] granted_block;
    logic [2:0] status;
  } out_t;

  function automatic logic [AW-1:0] level_base(input logic [LW-1:0] lev);
    logic [AW:0] full;
    full = (({{AW{1'b0}}, 1'b1}) << (MAX_ORDER + 1))
         - (({{AW{1'b0}}, 1'b1}) << ((MAX_ORDER + 1) - lev));
    return full[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] mark_pos(input logic [LW-1:0] lev,
                                             input logic [BW-1:0] blk);
    logic [BW-1:0] sh;
    sh = blk >> lev;
    return level_base(lev) + AW'(sh);
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/buddy_block_allocator.sv
`default_nettype none
// Binary buddy allocator over 2^total_order blocks. Pulse start while busy
// is low; one result appears for a single cycle with out_valid and must be
// taken then. After reset and after every write of total_order accepted
// while idle, a clearing pass runs over the mark memory with busy high. All
// mark accesses go through the single-port mark memory: an allocate scans
// marks from the requested level upward, then splits down level by level;
// a free reads the buddy at each level and merges upward while the buddy
// is free, then sets the mark of the merged block.
module buddy_block_allocator (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire bba_pkg::in_t in_data,
  output logic out_valid,
  output bba_pkg::out_t out_data,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import bba_pkg::*;

  state_t state_r, state_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [LW-1:0] lev_r, lev_nxt, k_r, k_nxt, tord_r, tord_nxt;
  logic [BW-1:0] blk_r, blk_nxt;
  out_t res_r, res_nxt;
  logic we;
  logic [AW-1:0] addr;
  logic [0:0] wdata, rdata;
  logic [LW-1:0] k_in;
  logic [SW:0] span;
  logic cfg_wr;
  logic [LW-1:0] lm1;

  bba_ram #(.WIDTH(1), .DEPTH(MARKS)) u_marks (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign pready = 1'b1;
  assign prdata = {28'd0, tord_r};
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign busy = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_data = res_r;
  assign lm1 = lev_r - LW'(1);

  always_comb begin
    k_in = LW'(15);
    for (int i = 15; i >= 0; i--) begin
      if ((17'd1 << i) >= {6'd0, in_data.size_blocks}) begin
        k_in = LW'(i);
      end
    end
    span = (SW+1)'(1) << k_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      pos_r <= '0;
      tord_r <= LW'(MAX_ORDER);
    end else begin
      state_r <= state_nxt;
      pos_r <= pos_nxt;
      tord_r <= tord_nxt;
    end
    lev_r <= lev_nxt;
    k_r <= k_nxt;
    blk_r <= blk_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt = pos_r;
    lev_nxt = lev_r;
    k_nxt = k_r;
    blk_nxt = blk_r;
    tord_nxt = tord_r;
    res_nxt = res_r;
    we = 1'b0;
    addr = pos_r;
    wdata = 1'b0;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        pos_nxt = pos_r + AW'(1);
        if (pos_r == AW'(MARKS - 1)) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        we = 1'b1;
        wdata = 1'b1;
        addr = level_base(tord_r);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_wr) begin
          tord_nxt = (pwdata[3:0] > LW'(MAX_ORDER)) ? LW'(MAX_ORDER) : pwdata[3:0];
          pos_nxt = '0;
          state_nxt = S_CLEAR;
        end else if (start) begin
          res_nxt = '0;
          k_nxt = k_in;
          lev_nxt = k_in;
          blk_nxt = in_data.block_index;
          pos_nxt = level_base(k_in);
          if (in_data.size_blocks == '0) begin
            res_nxt.status = ST_ZERO;
            state_nxt = S_DONE;
          end else if (k_in > tord_r) begin
            res_nxt.status = ST_TOO_LARGE;
            state_nxt = S_DONE;
          end else if (!in_data.op) begin
            state_nxt = S_SCAN_RD;
          end else if ((({1'b0, in_data.block_index} & (span[SW-1:0] - SW'(1))) != '0) ||
                       ({2'b0, in_data.block_index} + span > ((SW+1)'(1) << tord_r))) begin
            res_nxt.status = ST_BAD_FREE;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FREE_RD;
          end
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (rdata[0]) begin
          we = 1'b1;
          blk_nxt = BW'(pos_r - level_base(lev_r)) << lev_r;
          state_nxt = S_SPLIT;
        end else if (pos_r == level_base(tord_r)) begin
          res_nxt.status = ST_NO_MEM;
          state_nxt = S_DONE;
        end else begin
          pos_nxt = pos_r + AW'(1);
          if (pos_r + AW'(1) == level_base(lev_r + LW'(1))) begin
            lev_nxt = lev_r + LW'(1);
          end
          state_nxt = S_SCAN_RD;
        end
      end
      S_SPLIT: begin
        if (lev_r > k_r) begin
          we = 1'b1;
          wdata = 1'b1;
          addr = mark_pos(lm1, blk_r + (BW'(1) << lm1));
          lev_nxt = lm1;
        end else begin
          res_nxt.granted_block = blk_r;
          res_nxt.status = ST_OK;
          state_nxt = S_DONE;
        end
      end
      S_FREE_RD: begin
        addr = mark_pos(lev_r, blk_r ^ (BW'(1) << lev_r));
        state_nxt = (lev_r < tord_r) ? S_FREE_CHK : S_FREE_SET;
      end
      S_FREE_CHK: begin
        addr = mark_pos(lev_r, blk_r ^ (BW'(1) << lev_r));
        if (rdata[0]) begin
          we = 1'b1;
          blk_nxt = blk_r & ~(BW'(1) << lev_r);
          lev_nxt = lev_r + LW'(1);
          state_nxt = S_FREE_RD;
        end else begin
          state_nxt = S_FREE_SET;
        end
      end
      S_FREE_SET: begin
        we = 1'b1;
        wdata = 1'b1;
        addr = mark_pos(lev_r, blk_r);
        res_nxt.status = ST_OK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/core/bba_ram.sv
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2047
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: rtl/core/bba_checker.sv
`default_nettype none
module bba_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire bba_pkg::out_t out_data
);
  import bba_pkg::*;

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("not busy after input transfer");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= 3'd4) else $error("bad status code");

  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.granted_block == '0)
    else $error("nonzero block on error");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held two cycles");

  a_busy_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);
`default_nettype wire
